// ----- rtl/pdll_pkg.sv -----
// Shared types and codes for the positional doubly linked list.
`default_nettype none
package pdll_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 8;
  localparam int unsigned ValueW  = 32;

  typedef enum logic [KindW-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_END   = 3'd4,
    KIND_DEL_POS   = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,      // capture request, cursor <= head (tail for delete at end), step <= 1
    OP_FREE_RD,    // read free stack top
    OP_WALK_RD,    // read next link of cursor
    OP_WALK_ADV,   // cursor <= read next link, step++
    OP_NODE_RD,    // read prev and next of target node
    OP_INS_WR,     // write new node value/links, fix neighbour or head/tail
    OP_INS_FIX,    // write the second neighbour link
    OP_DEL_WR,     // fix first neighbour of removed node
    OP_DEL_FIX     // fix second neighbour, push node back on free stack
  } op_e;

  typedef struct packed {
    op_e  op;
    logic ins_front;  // insert goes at the head
    logic done;       // load result register
    logic [StatusW-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic list_empty;
    logic store_full;
    logic pos_zero;
    logic ins_pos_over;   // position > length + 1
    logic del_pos_over;   // position > length
    logic walk_done;      // step has reached target
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  pos;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/pdll_datapath.sv -----
// Datapath: node store, free stack, head/tail/length registers and cursor.
`default_nettype none
module pdll_datapath
  import pdll_pkg::*;
#(
  parameter int unsigned Capacity = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [ValueW-1:0]  value_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_stat_t                stat_o,
  output logic [StatusW-1:0]      status_o,
  output logic [$clog2(Capacity+1)-1:0] count_o
);

  localparam int unsigned IdxW  = $clog2(Capacity);
  localparam int unsigned LinkW = $clog2(Capacity+1);
  localparam logic [LinkW-1:0] NullLink = LinkW'(Capacity);
  localparam int unsigned CmpW  = (LinkW > PosW ? LinkW : PosW) + 1;

  logic [ValueW-1:0] node_value [Capacity];
  logic [LinkW-1:0]  next_link  [Capacity];
  logic [LinkW-1:0]  prev_link  [Capacity];
  logic [IdxW-1:0]   free_stack [Capacity];

  logic [LinkW-1:0] head_q, tail_q, top_q, len_q;
  logic [KindW-1:0] kind_q;
  logic [ValueW-1:0] value_q;
  logic [PosW-1:0]  pos_q;
  logic [LinkW-1:0] cur_q, step_q;
  logic [LinkW-1:0] rd_next_q, rd_prev_q;
  logic [IdxW-1:0]  new_q;
  logic [LinkW-1:0] p_q, q_q;   // neighbours for link updates
  logic             init_q;
  logic [IdxW-1:0]  init_idx_q;
  logic [StatusW-1:0] status_q;

  function automatic logic is_node(logic [LinkW-1:0] l);
    return l < NullLink;
  endfunction

  logic [CmpW-1:0] pos_w, len_w, tgt_w;
  assign pos_w = CmpW'(pos_q);
  assign len_w = CmpW'(len_q);
  // Insert walks to position-1, delete walks to position.
  assign tgt_w = (kind_q == KIND_DEL_POS) ? pos_w : pos_w - CmpW'(1);

  assign stat_o.list_empty   = !is_node(head_q);
  assign stat_o.store_full   = (top_q == '0);
  assign stat_o.pos_zero     = (pos_q == '0);
  assign stat_o.ins_pos_over = pos_w > len_w + CmpW'(1);
  assign stat_o.del_pos_over = pos_w > len_w;
  assign stat_o.walk_done    = CmpW'(step_q) >= tgt_w;
  assign stat_o.kind         = kind_q;
  assign stat_o.pos          = pos_q;

  // Free stack initialization sweep after reset; the stack fills one entry a cycle
  // but pops only read entries below top, which the sweep has already written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_idx_q <= '0;
    end else if (init_q) begin
      init_idx_q <= init_idx_q + IdxW'(1);
      if (init_idx_q == IdxW'(Capacity-1)) init_q <= 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NullLink;
      tail_q   <= NullLink;
      top_q    <= LinkW'(Capacity);
      len_q    <= '0;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.done) status_q <= cmd_i.status;
      unique case (cmd_i.op)
        OP_FREE_RD: top_q <= top_q - LinkW'(1);
        OP_INS_WR: begin
          if (!is_node(p_q)) head_q <= LinkW'(new_q);
          if (!is_node(q_q)) tail_q <= LinkW'(new_q);
          len_q <= len_q + LinkW'(1);
        end
        OP_DEL_WR: begin
          if (!is_node(rd_prev_q)) head_q <= rd_next_q;
          if (!is_node(rd_next_q)) tail_q <= rd_prev_q;
        end
        OP_DEL_FIX: begin
          top_q <= top_q + LinkW'(1);
          len_q <= len_q - LinkW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers and memories.
  always_ff @(posedge clk_i) begin
    if (init_q) free_stack[init_idx_q] <= init_idx_q;
    unique case (cmd_i.op)
      OP_LATCH: begin
        kind_q  <= kind_i;
        value_q <= value_i;
        pos_q   <= position_i;
        // Delete at the end starts from the tail, everything else from the head.
        cur_q   <= (kind_i == KIND_DEL_END) ? tail_q : head_q;
        step_q  <= LinkW'(1);
        p_q     <= (kind_i == KIND_INS_END) ? tail_q : NullLink;
        q_q     <= (kind_i == KIND_INS_END) ? NullLink : head_q;
        rd_next_q <= head_q;
      end
      OP_FREE_RD: new_q <= free_stack[IdxW'(top_q - LinkW'(1))];
      OP_WALK_RD: rd_next_q <= next_link[IdxW'(cur_q)];
      OP_WALK_ADV: begin
        cur_q  <= rd_next_q;
        step_q <= step_q + LinkW'(1);
      end
      OP_NODE_RD: begin
        if (kind_q == KIND_INS_POS) begin
          // Walk ended on the predecessor (or head when position is one).
          if (cmd_i.ins_front) begin
            p_q <= NullLink;
            q_q <= head_q;
          end else begin
            p_q <= cur_q;
            q_q <= next_link[IdxW'(cur_q)];
          end
        end else begin
          rd_prev_q <= prev_link[IdxW'(cur_q)];
          rd_next_q <= next_link[IdxW'(cur_q)];
        end
      end
      OP_INS_WR: begin
        node_value[new_q] <= value_q;
        prev_link[new_q]  <= p_q;
        next_link[new_q]  <= q_q;
        if (is_node(q_q)) prev_link[IdxW'(q_q)] <= LinkW'(new_q);
      end
      OP_INS_FIX: if (is_node(p_q)) next_link[IdxW'(p_q)] <= LinkW'(new_q);
      OP_DEL_WR: if (is_node(rd_prev_q)) next_link[IdxW'(rd_prev_q)] <= rd_next_q;
      OP_DEL_FIX: begin
        if (is_node(rd_next_q)) prev_link[IdxW'(rd_next_q)] <= rd_prev_q;
        free_stack[IdxW'(top_q)] <= IdxW'(cur_q);
      end
      default: ;
    endcase
  end

  assign status_o = status_q;
  assign count_o  = len_q;

endmodule
`default_nettype wire

// ----- rtl/pdll_ctrl.sv -----
// Controller state machine sequencing each list request.
`default_nettype none
module pdll_ctrl
  import pdll_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_WALK  = 10'b0000000100,
    S_ADV   = 10'b0000001000,
    S_NODE  = 10'b0000010000,
    S_INSWR = 10'b0000100000,
    S_INSFX = 10'b0001000000,
    S_DELWR = 10'b0010000000,
    S_DELFX = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.done;
    end
  end

  logic is_ins, is_del;
  assign is_ins = (stat_i.kind == KIND_INS_FRONT) || (stat_i.kind == KIND_INS_END) ||
                  (stat_i.kind == KIND_INS_POS);
  assign is_del = (stat_i.kind == KIND_DEL_FRONT) || (stat_i.kind == KIND_DEL_END) ||
                  (stat_i.kind == KIND_DEL_POS);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, ins_front: 1'b0, done: 1'b0, status: ST_OK};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        // Request checks in the same order as the list semantics require.
        if (stat_i.kind == KIND_INS_POS && stat_i.pos_zero) begin
          cmd_o.done = 1'b1; cmd_o.status = ST_INVALID; state_d = S_DONE;
        end else if (is_ins && stat_i.store_full) begin
          cmd_o.done = 1'b1; cmd_o.status = ST_FULL; state_d = S_DONE;
        end else if (stat_i.kind == KIND_INS_POS && stat_i.ins_pos_over) begin
          cmd_o.done = 1'b1; cmd_o.status = ST_NOT_FOUND; state_d = S_DONE;
        end else if (is_del && stat_i.list_empty) begin
          cmd_o.done = 1'b1; cmd_o.status = ST_EMPTY; state_d = S_DONE;
        end else if (stat_i.kind == KIND_DEL_POS && stat_i.pos_zero) begin
          cmd_o.done = 1'b1; cmd_o.status = ST_INVALID; state_d = S_DONE;
        end else if (stat_i.kind == KIND_DEL_POS && stat_i.del_pos_over) begin
          cmd_o.done = 1'b1; cmd_o.status = ST_NOT_FOUND; state_d = S_DONE;
        end else if (is_ins) begin
          cmd_o.op = OP_FREE_RD;
          state_d  = (stat_i.kind == KIND_INS_POS) ? S_WALK : S_INSWR;
        end else if (is_del) begin
          state_d = (stat_i.kind == KIND_DEL_POS) ? S_WALK : S_NODE;
        end else begin
          cmd_o.done = 1'b1; cmd_o.status = ST_INVALID; state_d = S_DONE;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          state_d = S_NODE;
        end else begin
          cmd_o.op = OP_WALK_RD;
          state_d  = S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.op = OP_WALK_ADV;
        state_d  = S_WALK;
      end
      S_NODE: begin
        cmd_o.op        = OP_NODE_RD;
        cmd_o.ins_front = (stat_i.pos == PosW'(1));
        state_d         = is_ins ? S_INSWR : S_DELWR;
      end
      S_INSWR: begin
        cmd_o.op = OP_INS_WR;
        state_d  = S_INSFX;
      end
      S_INSFX: begin
        cmd_o.op = OP_INS_FIX;
        cmd_o.done = 1'b1;
        state_d = S_DONE;
      end
      S_DELWR: begin
        cmd_o.op = OP_DEL_WR;
        state_d  = S_DELFX;
      end
      S_DELFX: begin
        cmd_o.op = OP_DEL_FIX;
        cmd_o.done = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- rtl/positional_doubly_linked_list_top.sv -----
// Top level of the positional doubly linked list.
//
//  channel   signals                                direction  transaction
//  request   start_i, busy_o, kind_i, value_i,      in         start_i && !busy_o
//            position_i
//  result    done_o, status_o, element_count_o      out        done_o (one cycle)
//
// A request that fails its checks goes from the decode state straight to the done state.
// An insert at the front or end passes the free-stack read, the node write and the
// link fix; a delete at the front or end the node read, the unlink write and the link
// fix. A positional request first walks the next links, one read and one advance each.
// After reset the free stack is filled one entry per cycle,
// during which no request may start.
// The result strobe is one cycle wide and cannot be held off.
`default_nettype none
module positional_doubly_linked_list_top
  import pdll_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [KindW-1:0]      kind_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic [PosW-1:0]       position_i,
  output logic                       done_o,
  output logic [StatusW-1:0]         status_o,
  output logic [$clog2(CAPACITY+1)-1:0] element_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy_ctrl;
  logic     init_busy_q;
  logic [$clog2(CAPACITY+1)-1:0] init_cnt_q;

  // Holds requests off while the free stack is being filled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_cnt_q  <= '0;
    end else if (init_busy_q) begin
      init_cnt_q <= init_cnt_q + ($clog2(CAPACITY+1))'(1);
      if (init_cnt_q == ($clog2(CAPACITY+1))'(CAPACITY - 1)) init_busy_q <= 1'b0;
    end
  end

  pdll_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i && !init_busy_q),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_ctrl),
    .done_o (done_o)
  );

  pdll_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kind_i    (kind_i),
    .value_i   (value_i),
    .position_i(position_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .status_o  (status_o),
    .count_o   (element_count_o)
  );

  assign busy_o = busy_ctrl || init_busy_q;

endmodule
`default_nettype wire

// ----- sim/pdll_checker.sv -----
// Checker that predicts and compares the results of the positional linked list.
`timescale 1ns / 1ps
module pdll_checker
  import pdll_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [KindW-1:0]              kind_i,
  input  logic signed [ValueW-1:0]      value_i,
  input  logic [PosW-1:0]               position_i,
  input  logic                          done_i,
  input  logic [StatusW-1:0]            status_i,
  input  logic [$clog2(CAPACITY+1)-1:0] element_count_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned CountW = $clog2(CAPACITY+1);

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } outcome_t;

  logic signed [ValueW-1:0] list_values[$];
  outcome_t                 outcomes[$];

  // Applies one request to the shadow list and returns its outcome.
  function automatic outcome_t apply_request(logic [KindW-1:0] kind,
                                             logic signed [ValueW-1:0] value,
                                             logic [PosW-1:0] pos);
    outcome_t res;
    int       len;
    len        = list_values.size();
    res.status = ST_OK;
    case (kind)
      KIND_INS_FRONT, KIND_INS_END: begin
        if (len >= CAPACITY) res.status = ST_FULL;
        else if (kind == KIND_INS_FRONT) list_values.push_front(value);
        else list_values.push_back(value);
      end
      KIND_INS_POS: begin
        if (pos == 0) res.status = ST_INVALID;
        else if (len >= CAPACITY) res.status = ST_FULL;
        else if (pos > len + 1) res.status = ST_NOT_FOUND;
        else list_values.insert(pos - 1, value);
      end
      KIND_DEL_FRONT, KIND_DEL_END: begin
        if (len == 0) res.status = ST_EMPTY;
        else if (kind == KIND_DEL_FRONT) void'(list_values.pop_front());
        else void'(list_values.pop_back());
      end
      KIND_DEL_POS: begin
        if (len == 0) res.status = ST_EMPTY;
        else if (pos == 0) res.status = ST_INVALID;
        else if (pos > len) res.status = ST_NOT_FOUND;
        else list_values.delete(pos - 1);
      end
      default: res.status = ST_INVALID;
    endcase
    res.count = CountW'(list_values.size());
    return res;
  endfunction

  assign pending_o = outcomes.size();

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      list_values.delete();
      outcomes.delete();
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (outcomes.size() == 0) begin
          $display("%0t: result with no transaction pending: status %0d count %0d",
                   $time, status_i, element_count_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = outcomes.pop_front();
          if (want.status !== status_i || want.count !== element_count_i) begin
            $display("%0t: mismatch: expected status %0d count %0d, got status %0d count %0d",
                     $time, want.status, want.count, status_i, element_count_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) outcomes.push_back(apply_request(kind_i, value_i, position_i));
    end
  end

endmodule

// ----- sim/positional_doubly_linked_list_top_tb.sv -----
// Testbench top: drives requests into the linked list and gives the verdict.
`timescale 1ns / 1ps
module positional_doubly_linked_list_top_tb;
  import pdll_pkg::*;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned CountW    = $clog2(CAPACITY+1);
  localparam int          IdleLimit = 3000;
  localparam logic [KindW-1:0] KindSpareLo = 3'd6;
  localparam logic [KindW-1:0] KindSpareHi = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KindW-1:0]         kind = '0;
  logic signed [ValueW-1:0] value = '0;
  logic [PosW-1:0]          position = '0;
  logic                     done;
  logic [StatusW-1:0]       status;
  logic [CountW-1:0]        element_count;
  int                       fail_count;
  int                       pending;
  int                       idle_cycles = 0;
  int                       shadow_len = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  positional_doubly_linked_list_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .kind_i(kind), .value_i(value), .position_i(position),
    .done_o(done), .status_o(status), .element_count_o(element_count)
  );

  pdll_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .kind_i(kind), .value_i(value), .position_i(position),
    .done_i(done), .status_i(status), .element_count_i(element_count),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The run ends if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("positional_doubly_linked_list_top_tb: FAIL");
      $finish;
    end
  end

  // Issues one transaction; returns after the edge that accepts it.
  task automatic send(logic [KindW-1:0] k, logic signed [ValueW-1:0] v,
                      logic [PosW-1:0] p);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    = 1'b1;
    kind     = k;
    value    = v;
    position = p;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    start = 1'b0;
    // Rough length tracking only steers the random mix.
    case (k)
      KIND_INS_FRONT, KIND_INS_END: if (shadow_len < CAPACITY) shadow_len++;
      KIND_INS_POS:
        if (p != 0 && shadow_len < CAPACITY && p <= shadow_len + 1) shadow_len++;
      KIND_DEL_FRONT, KIND_DEL_END: if (shadow_len > 0) shadow_len--;
      KIND_DEL_POS: if (shadow_len > 0 && p != 0 && p <= shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  function automatic logic [PosW-1:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return PosW'($urandom_range(0, 255));
      1:       return 0;
      2:       return PosW'(shadow_len + 1);
      3:       return PosW'(shadow_len + 2);
      default: return PosW'($urandom_range(1, shadow_len + 1));
    endcase
  endfunction

  initial begin
    bit fill_phase;
    int draw;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, invalid positions, value extremes, spare kinds.
    send(KIND_DEL_FRONT, 0, 0);
    send(KIND_DEL_END, 0, 0);
    send(KIND_DEL_POS, 0, 0);
    send(KIND_DEL_POS, 0, 1);
    send(KIND_INS_POS, 32'sh7fffffff, 0);
    send(KIND_INS_POS, 32'sh7fffffff, 2);
    send(KIND_INS_POS, 32'sh80000000, 1);
    send(KIND_INS_FRONT, -1, 8'hff);
    send(KIND_INS_END, 32'sh7fffffff, 0);
    send(KIND_INS_POS, 5, 4);
    send(KIND_INS_POS, 6, 3);
    send(KIND_INS_POS, 7, 9);
    send(KIND_DEL_POS, 0, 0);
    send(KIND_DEL_POS, 0, 8'hff);
    send(KIND_DEL_POS, 0, 5);
    send(KIND_DEL_POS, 0, 2);
    send(KIND_DEL_END, 0, 0);
    send(KIND_DEL_FRONT, 0, 0);
    send(KindSpareLo, -1, 8'hff);
    send(KindSpareHi, 0, 1);

    // Random: alternate between filling the store and draining it.
    fill_phase = 1'b1;
    for (int i = 0; i < 2000; i++) begin
      if (shadow_len >= CAPACITY && $urandom_range(0, 7) == 0) fill_phase = 1'b0;
      if (shadow_len == 0 && $urandom_range(0, 3) == 0) fill_phase = 1'b1;
      draw = $urandom_range(0, 99);
      if (draw < 3) begin
        send($urandom_range(0, 1) ? KindSpareLo : KindSpareHi, $urandom, PosW'($urandom));
      end else if ((fill_phase && draw < 75) || (!fill_phase && draw >= 75)) begin
        case ($urandom_range(0, 2))
          0:       send(KIND_INS_FRONT, $urandom, PosW'($urandom));
          1:       send(KIND_INS_END, $urandom, PosW'($urandom));
          default: send(KIND_INS_POS, $urandom, pick_position());
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       send(KIND_DEL_FRONT, $urandom, PosW'($urandom));
          1:       send(KIND_DEL_END, $urandom, PosW'($urandom));
          default: send(KIND_DEL_POS, $urandom, pick_position());
        endcase
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("positional_doubly_linked_list_top_tb: PASS");
    end else begin
      $display("positional_doubly_linked_list_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pdll_pkg.sv
rtl/pdll_datapath.sv
rtl/pdll_ctrl.sv
rtl/positional_doubly_linked_list_top.sv
sim/pdll_checker.sv
sim/positional_doubly_linked_list_top_tb.sv
